/* src/rsa_pkg.sv */
// Shared constants, types and command codes of the RPN stack engine.
`default_nettype none

package rsa_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        CMD_PUSH_INT = 5'd0,
        CMD_TRUE     = 5'd1,
        CMD_FALSE    = 5'd2,
        CMD_NOT      = 5'd3,
        CMD_PRINT    = 5'd4,
        CMD_CLEAR    = 5'd5,
        CMD_DROP     = 5'd6,
        CMD_DUP      = 5'd7,
        CMD_SWAP     = 5'd8,
        CMD_ADD      = 5'd9,
        CMD_SUB      = 5'd10,
        CMD_MUL      = 5'd11,
        CMD_DIV      = 5'd12,
        CMD_MOD      = 5'd13,
        CMD_GE       = 5'd14,
        CMD_EQ       = 5'd15,
        CMD_LE       = 5'd16,
        CMD_GT       = 5'd17,
        CMD_LT       = 5'd18
    } t_cmd;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_NOT_INT  = 3'd2,
        ERR_NOT_BOOL = 3'd3,
        ERR_DIV_ZERO = 3'd4,
        ERR_FULL     = 3'd5,
        ERR_UNIMPL   = 3'd6
    } t_err;

    typedef enum logic [3:0] {
        OP_PUSH,
        OP_NOT,
        OP_PRINT,
        OP_CLEAR,
        OP_DROP,
        OP_DUP,
        OP_SWAP,
        OP_BINARY,
        OP_BAD
    } t_op_kind;

    typedef enum logic [3:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD,
        ALU_GE,
        ALU_EQ,
        ALU_LE,
        ALU_GT,
        ALU_LT
    } t_alu;

    typedef struct packed {
        logic              tag;
        logic [DATA_W-1:0] value;
    } t_entry;

    typedef struct packed {
        t_op_kind kind;
        t_alu     alu;
        t_entry   entry;
    } t_op;

    typedef struct packed {
        logic [4:0]         cmd;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         error_code;
        logic               top_valid;
        logic signed [31:0] top_value;
        logic               top_is_bool;
        logic               print_strobe;
        logic [6:0]         stack_depth;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic              is_mod;
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] result;
    } t_div_rsp;

endpackage

`default_nettype wire

/* src/rpn_stack_alu.sv */
// Top level of the typed RPN stack engine.
//
// Typed RPN stack engine. Each transfer on the input channel carries one
// command (push int, true, false, not, print, clear, drop, dup, swap, add,
// sub, mul, div, mod, ge, eq, le, gt, lt; other codes are unimplemented) and
// produces exactly one result transfer with the error code, a view of the top
// entry and the depth afterward. The front end classifies commands into a
// two-entry queue, so new commands are taken while the executor works and
// while a result waits in the output register. The executor handles one
// command at a time in steps: read the top two entries from the stack memory,
// execute and write back, read the new top, load the result register. Swap
// adds a step for its second write, which needs the single memory write port
// again, and div and mod wait on a radix-2 divider producing one quotient bit
// per cycle.
// Operands are popped before they are checked, so a failed command loses what
// it popped. Arithmetic wraps at 32 bits and division truncates toward zero.
// The stack memory needs no clearing after reset: only entries below the
// depth count are ever shown.
`default_nettype none

module rpn_stack_alu (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire rsa_pkg::t_in_item i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rsa_pkg::t_out_item o_item
);

    // front end to queue
    logic              q_push;
    logic              q_full;
    rsa_pkg::t_op      q_in;
    // queue to executor
    logic              q_valid;
    logic              q_pop;
    rsa_pkg::t_op      q_out;
    // executor to divider
    rsa_pkg::t_div_req div_req;
    rsa_pkg::t_div_rsp div_rsp;

    // Classify each command as it transfers in.
    rsa_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_op    (q_in)
    );

    // Decouple acceptance from execution.
    rsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // Shared iterative divider for div and mod.
    rsa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Stack memory, sequencer and result register.
    rsa_exec u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .o_op_pop   (q_pop),
        .i_op       (q_out),
        .o_div_req  (div_req),
        .i_div_rsp  (div_rsp),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_item     (o_item)
    );

endmodule

`default_nettype wire

/* src/rsa_front.sv */
// Front end: accept commands and classify them into operations for the queue.
`default_nettype none

module rsa_front (
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire rsa_pkg::t_in_item i_item,
    input  wire logic            i_full,
    output logic                 o_push,
    output rsa_pkg::t_op         o_op
);

    rsa_pkg::t_cmd cmd;

    assign cmd     = rsa_pkg::t_cmd'(i_item.cmd);
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_op.kind        = rsa_pkg::OP_BAD;
        o_op.alu         = rsa_pkg::ALU_ADD;
        o_op.entry.tag   = 1'b0;
        o_op.entry.value = i_item.push_value;
        unique case (cmd)
            rsa_pkg::CMD_PUSH_INT: o_op.kind = rsa_pkg::OP_PUSH;
            rsa_pkg::CMD_TRUE: begin
                o_op.kind        = rsa_pkg::OP_PUSH;
                o_op.entry.tag   = 1'b1;
                o_op.entry.value = rsa_pkg::DATA_W'(1);
            end
            rsa_pkg::CMD_FALSE: begin
                o_op.kind        = rsa_pkg::OP_PUSH;
                o_op.entry.tag   = 1'b1;
                o_op.entry.value = '0;
            end
            rsa_pkg::CMD_NOT:   o_op.kind = rsa_pkg::OP_NOT;
            rsa_pkg::CMD_PRINT: o_op.kind = rsa_pkg::OP_PRINT;
            rsa_pkg::CMD_CLEAR: o_op.kind = rsa_pkg::OP_CLEAR;
            rsa_pkg::CMD_DROP:  o_op.kind = rsa_pkg::OP_DROP;
            rsa_pkg::CMD_DUP:   o_op.kind = rsa_pkg::OP_DUP;
            rsa_pkg::CMD_SWAP:  o_op.kind = rsa_pkg::OP_SWAP;
            rsa_pkg::CMD_ADD: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_ADD;
            end
            rsa_pkg::CMD_SUB: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_SUB;
            end
            rsa_pkg::CMD_MUL: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_MUL;
            end
            rsa_pkg::CMD_DIV: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_DIV;
            end
            rsa_pkg::CMD_MOD: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_MOD;
            end
            rsa_pkg::CMD_GE: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_GE;
            end
            rsa_pkg::CMD_EQ: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_EQ;
            end
            rsa_pkg::CMD_LE: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_LE;
            end
            rsa_pkg::CMD_GT: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_GT;
            end
            rsa_pkg::CMD_LT: begin
                o_op.kind = rsa_pkg::OP_BINARY;
                o_op.alu  = rsa_pkg::ALU_LT;
            end
            default: o_op.kind = rsa_pkg::OP_BAD;
        endcase
    end

endmodule

`default_nettype wire

/* src/rsa_queue.sv */
// Short FIFO of classified operations between the front end and the executor.
`default_nettype none

module rsa_queue (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire rsa_pkg::t_op i_data,
    output logic          o_full,
    input  wire logic     i_pop,
    output logic          o_valid,
    output rsa_pkg::t_op  o_data
);

    rsa_pkg::t_op                  r_slot [rsa_pkg::QUEUE_DEPTH];
    logic [rsa_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [rsa_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [rsa_pkg::QCNT_W-1:0]    r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_full  = (r_count == rsa_pkg::QCNT_W'(rsa_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == rsa_pkg::QPTR_W'(rsa_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == rsa_pkg::QPTR_W'(rsa_pkg::QUEUE_DEPTH - 1))
                          ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* src/rsa_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module rsa_div (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire rsa_pkg::t_div_req i_req,
    output rsa_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(rsa_pkg::DATA_W);

    logic                       r_busy;
    logic                       r_done;
    logic [CNT_W-1:0]           r_count;
    logic [rsa_pkg::DATA_W-1:0] r_rem;
    logic [rsa_pkg::DATA_W-1:0] r_quo;
    logic [rsa_pkg::DATA_W-1:0] r_den;
    logic                       r_nneg;
    logic                       r_qneg;
    logic                       r_is_mod;

    logic [rsa_pkg::DATA_W:0]   shifted;
    logic [rsa_pkg::DATA_W:0]   diff;
    logic [rsa_pkg::DATA_W-1:0] num_mag;
    logic [rsa_pkg::DATA_W-1:0] den_mag;

    assign num_mag = i_req.num[rsa_pkg::DATA_W-1] ? (~i_req.num + 1'b1) : i_req.num;
    assign den_mag = i_req.den[rsa_pkg::DATA_W-1] ? (~i_req.den + 1'b1) : i_req.den;
    assign shifted = {r_rem, r_quo[rsa_pkg::DATA_W-1]};
    assign diff    = shifted - {1'b0, r_den};

    // Apply signs: quotient negative when signs differ, remainder follows dividend.
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_is_mod ? (r_nneg ? (~r_rem + 1'b1) : r_rem)
                                   : (r_qneg ? (~r_quo + 1'b1) : r_quo);

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem    <= '0;
            r_quo    <= num_mag;
            r_den    <= den_mag;
            r_nneg   <= i_req.num[rsa_pkg::DATA_W-1];
            r_qneg   <= i_req.num[rsa_pkg::DATA_W-1] ^ i_req.den[rsa_pkg::DATA_W-1];
            r_is_mod <= i_req.is_mod;
        end else if (r_busy) begin
            if (!diff[rsa_pkg::DATA_W]) begin
                r_rem <= diff[rsa_pkg::DATA_W-1:0];
                r_quo <= {r_quo[rsa_pkg::DATA_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[rsa_pkg::DATA_W-1:0];
                r_quo <= {r_quo[rsa_pkg::DATA_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == CNT_W'(rsa_pkg::DATA_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

/* src/rsa_exec.sv */
// Back end: stack memory, sequencer, ALU and result register.
`default_nettype none

module rsa_exec (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_op_valid,
    output logic               o_op_pop,
    input  wire rsa_pkg::t_op  i_op,
    output rsa_pkg::t_div_req  o_div_req,
    input  wire rsa_pkg::t_div_rsp i_div_rsp,
    output logic               o_valid,
    input  wire logic          i_ready,
    output rsa_pkg::t_out_item o_item
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_OPER,
        S_DIV,
        S_WR2,
        S_TOP,
        S_LOAD
    } t_state;

    localparam int AW = rsa_pkg::ADDR_W;
    localparam int DW = rsa_pkg::DEPTH_W;

    rsa_pkg::t_entry r_mem [rsa_pkg::STACK_DEPTH];

    t_state             r_state, n_state;
    logic [DW-1:0]      r_depth, n_depth;
    rsa_pkg::t_err      r_err, n_err;
    logic               r_strobe, n_strobe;
    rsa_pkg::t_op       r_op;
    rsa_pkg::t_entry    r_rd0;
    rsa_pkg::t_entry    r_rd1;
    rsa_pkg::t_out_item r_out;
    logic               r_out_valid;

    logic               mem_we;
    logic [AW-1:0]      mem_wa;
    rsa_pkg::t_entry    mem_wd;
    logic               rd_en;
    logic [AW-1:0]      rd_addr0;
    logic [AW-1:0]      rd_addr1;
    logic               load_out;

    logic [DW-1:0]      d_m1;
    logic [DW-1:0]      d_m2;
    logic               is_full;
    logic [31:0]        opa;
    logic [31:0]        opb;
    logic [31:0]        product;
    rsa_pkg::t_entry    alu_res;

    assign d_m1    = r_depth - 1'b1;
    assign d_m2    = r_depth - 2'd2;
    assign is_full = (r_depth == DW'(rsa_pkg::STACK_DEPTH));
    assign opa     = r_rd1.value;
    assign opb     = r_rd0.value;
    assign product = opa * opb;

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        alu_res.tag   = 1'b1;
        alu_res.value = '0;
        unique case (r_op.alu)
            rsa_pkg::ALU_ADD: begin
                alu_res.tag   = 1'b0;
                alu_res.value = opa + opb;
            end
            rsa_pkg::ALU_SUB: begin
                alu_res.tag   = 1'b0;
                alu_res.value = opa - opb;
            end
            rsa_pkg::ALU_MUL: begin
                alu_res.tag   = 1'b0;
                alu_res.value = product;
            end
            rsa_pkg::ALU_GE: alu_res.value = {31'b0, $signed(opa) >= $signed(opb)};
            rsa_pkg::ALU_EQ: alu_res.value = {31'b0, opa == opb};
            rsa_pkg::ALU_LE: alu_res.value = {31'b0, $signed(opa) <= $signed(opb)};
            rsa_pkg::ALU_GT: alu_res.value = {31'b0, $signed(opa) > $signed(opb)};
            rsa_pkg::ALU_LT: alu_res.value = {31'b0, $signed(opa) < $signed(opb)};
            default: begin
                // division and modulo go through the divider
                alu_res.tag   = 1'b0;
                alu_res.value = '0;
            end
        endcase
    end

    always_comb begin
        n_state          = r_state;
        n_depth          = r_depth;
        n_err            = r_err;
        n_strobe         = r_strobe;
        mem_we           = 1'b0;
        mem_wa           = r_depth[AW-1:0];
        mem_wd           = r_op.entry;
        rd_en            = 1'b0;
        rd_addr0         = d_m1[AW-1:0];
        rd_addr1         = d_m2[AW-1:0];
        o_op_pop         = 1'b0;
        o_div_req.start  = 1'b0;
        o_div_req.is_mod = (r_op.alu == rsa_pkg::ALU_MOD);
        o_div_req.num    = opa;
        o_div_req.den    = opb;
        load_out         = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // fetch the two top entries while the operation is taken
                if (i_op_valid) begin
                    o_op_pop = 1'b1;
                    rd_en    = 1'b1;
                    n_state  = S_OPER;
                end
            end
            S_OPER: begin
                n_err    = rsa_pkg::ERR_OK;
                n_strobe = 1'b0;
                n_state  = S_TOP;
                unique case (r_op.kind)
                    rsa_pkg::OP_PUSH: begin
                        if (is_full) begin
                            n_err = rsa_pkg::ERR_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                    rsa_pkg::OP_NOT: begin
                        if (r_depth == '0) begin
                            n_err = rsa_pkg::ERR_EMPTY;
                        end else if (!r_rd0.tag) begin
                            n_err   = rsa_pkg::ERR_NOT_BOOL;
                            n_depth = d_m1;
                        end else begin
                            mem_we       = 1'b1;
                            mem_wa       = d_m1[AW-1:0];
                            mem_wd.tag   = 1'b1;
                            mem_wd.value = {31'b0, ~r_rd0.value[0]};
                        end
                    end
                    rsa_pkg::OP_PRINT: begin
                        if (r_depth == '0) begin
                            n_err = rsa_pkg::ERR_EMPTY;
                        end else begin
                            n_strobe = 1'b1;
                        end
                    end
                    rsa_pkg::OP_CLEAR: n_depth = '0;
                    rsa_pkg::OP_DROP: begin
                        if (r_depth == '0) begin
                            n_err = rsa_pkg::ERR_EMPTY;
                        end else begin
                            n_depth = d_m1;
                        end
                    end
                    rsa_pkg::OP_DUP: begin
                        if (r_depth == '0) begin
                            n_err = rsa_pkg::ERR_EMPTY;
                        end else if (is_full) begin
                            n_err = rsa_pkg::ERR_FULL;
                        end else begin
                            mem_we  = 1'b1;
                            mem_wd  = r_rd0;
                            n_depth = r_depth + 1'b1;
                        end
                    end
                    rsa_pkg::OP_SWAP: begin
                        if (r_depth == '0) begin
                            n_err = rsa_pkg::ERR_EMPTY;
                        end else if (r_depth == DW'(1)) begin
                            n_err   = rsa_pkg::ERR_EMPTY;
                            n_depth = '0;
                        end else begin
                            // old top goes below, old second goes on top next cycle
                            mem_we  = 1'b1;
                            mem_wa  = d_m2[AW-1:0];
                            mem_wd  = r_rd0;
                            n_state = S_WR2;
                        end
                    end
                    rsa_pkg::OP_BINARY: begin
                        if (r_depth == '0) begin
                            n_err = rsa_pkg::ERR_EMPTY;
                        end else if (r_depth == DW'(1)) begin
                            n_err   = rsa_pkg::ERR_EMPTY;
                            n_depth = '0;
                        end else begin
                            n_depth = d_m2;
                            if (r_rd0.tag || r_rd1.tag) begin
                                n_err = rsa_pkg::ERR_NOT_INT;
                            end else if ((r_op.alu == rsa_pkg::ALU_DIV ||
                                          r_op.alu == rsa_pkg::ALU_MOD)) begin
                                if (opb == '0) begin
                                    n_err = rsa_pkg::ERR_DIV_ZERO;
                                end else begin
                                    o_div_req.start = 1'b1;
                                    n_state         = S_DIV;
                                end
                            end else begin
                                mem_we  = 1'b1;
                                mem_wa  = d_m2[AW-1:0];
                                mem_wd  = alu_res;
                                n_depth = d_m1;
                            end
                        end
                    end
                    default: n_err = rsa_pkg::ERR_UNIMPL;
                endcase
            end
            S_DIV: begin
                if (i_div_rsp.done) begin
                    mem_we       = 1'b1;
                    mem_wd.tag   = 1'b0;
                    mem_wd.value = i_div_rsp.result;
                    n_depth      = r_depth + 1'b1;
                    n_state      = S_TOP;
                end
            end
            S_WR2: begin
                mem_we  = 1'b1;
                mem_wa  = d_m1[AW-1:0];
                mem_wd  = r_rd1;
                n_state = S_TOP;
            end
            S_TOP: begin
                rd_en   = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // hold until the result register is free
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rd0 <= r_mem[rd_addr0];
            r_rd1 <= r_mem[rd_addr1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_depth     <= '0;
            r_err       <= rsa_pkg::ERR_OK;
            r_strobe    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_depth  <= n_depth;
            r_err    <= n_err;
            r_strobe <= n_strobe;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_op_pop) begin
            r_op <= i_op;
        end
        if (load_out) begin
            r_out.error_code   <= r_err;
            r_out.top_valid    <= (r_depth != '0);
            r_out.top_value    <= (r_depth != '0) ? r_rd0.value : '0;
            r_out.top_is_bool  <= (r_depth != '0) && r_rd0.tag;
            r_out.print_strobe <= r_strobe;
            r_out.stack_depth  <= 7'(r_depth);
        end
    end

endmodule

`default_nettype wire
